/* hdl/cerq_pkg.sv */
// Shared types and constants for the coalescing event ring queue.
// No dependencies; used by the top-level queue module.
package cerq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_FLUSH = 2'd1,
        OP_POP   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        logic [7:0]         ev_type;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [23:0]        data;
    } t_entry;

    localparam logic [0:0] CFG_MOVE_CODE   = 1'b0;
    localparam logic [0:0] CFG_SCROLL_CODE = 1'b1;

    localparam logic [7:0] MOVE_CODE_RESET   = 8'd1;
    localparam logic [7:0] SCROLL_CODE_RESET = 8'd2;

endpackage

/* hdl/cerq_sat_add.sv */
// Saturating 16-bit signed adder pair for accumulating scroll deltas.
// Depends on nothing but its ports.
module cerq_sat_add (
    input  logic signed [15:0] i_acc_x,
    input  logic signed [15:0] i_acc_y,
    input  logic signed [15:0] i_add_x,
    input  logic signed [15:0] i_add_y,
    output logic signed [15:0] o_sum_x,
    output logic signed [15:0] o_sum_y
);

    logic signed [16:0] wide_x;
    logic signed [16:0] wide_y;

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v[16] != v[15]) begin
            r = v[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    assign wide_x  = 17'(i_acc_x) + 17'(i_add_x);
    assign wide_y  = 17'(i_acc_y) + 17'(i_add_y);
    assign o_sum_x = sat16(wide_x);
    assign o_sum_y = sat16(wide_y);

endmodule

/* hdl/coalescing_event_ring_queue.sv */
// Top level of the coalescing event ring queue: ring memory, coalescing slots, control.
// Depends on cerq_pkg and cerq_sat_add.
//
// An item is accepted in every cycle while the result side keeps up. Each item waits in
// the input register and its result is registered in the output register. A flush that
// moves both the pending move and the pending scroll event into the ring holds back the
// next item while the second entry is written, because the ring memory has a single
// write port. The ring memory needs no clearing pass after reset, and configuration
// writes take effect at once.
module coalescing_event_ring_queue #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic [7:0]         i_event_type,
    input  logic signed [15:0] i_delta_x,
    input  logic signed [15:0] i_delta_y,
    input  logic [23:0]        i_event_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_pop_valid,
    output logic [7:0]         o_out_type,
    output logic signed [15:0] o_out_delta_x,
    output logic signed [15:0] o_out_delta_y,
    output logic [23:0]        o_out_data,
    output logic               o_dropped_oldest,
    output logic [6:0]         o_pending_size,
    output logic               o_all_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH + 3);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    logic [7:0]             r_cfg_move;
    logic [7:0]             r_cfg_scroll;

    logic                   r_s_valid;
    cerq_pkg::t_op          r_s_op;
    cerq_pkg::t_entry       r_s_entry;

    logic [PW-1:0]          r_rp;
    logic [PW-1:0]          r_wp;
    logic [CW-1:0]          r_count;
    logic                   r_move_pend;
    logic                   r_scroll_pend;
    cerq_pkg::t_entry       r_move_slot;
    cerq_pkg::t_entry       r_scroll_slot;
    logic                   r_defer;
    logic [PW-1:0]          r_defer_addr;

    cerq_pkg::t_entry       r_mem [DEPTH];

    logic                   r_o_valid;
    logic                   r_o_pop_valid;
    cerq_pkg::t_entry       r_o_entry;
    logic                   r_o_dropped;
    logic [6:0]             r_o_size;
    logic                   r_o_empty;

    logic [PW-1:0]          n_rp;
    logic [PW-1:0]          n_wp;
    logic [CW-1:0]          n_count;
    logic                   n_move_pend;
    logic                   n_scroll_pend;
    cerq_pkg::t_entry       n_move_slot;
    cerq_pkg::t_entry       n_scroll_slot;

    logic                   s_fire;
    logic                   s_two_wr;
    logic                   s_pop_hit;
    logic                   s_dropped;
    logic                   wr_en;
    logic [PW-1:0]          wr_addr;
    cerq_pkg::t_entry       wr_data;
    logic                   fl_wr1;
    logic                   fl_wr2;
    logic [CW-1:0]          fl_count1;
    logic [SW-1:0]          s_size;
    logic signed [15:0]     sum_x;
    logic signed [15:0]     sum_y;

    cerq_sat_add u_sat_add (
        .i_acc_x (r_scroll_slot.dx),
        .i_acc_y (r_scroll_slot.dy),
        .i_add_x (r_s_entry.dx),
        .i_add_y (r_s_entry.dy),
        .o_sum_x (sum_x),
        .o_sum_y (sum_y)
    );

    assign s_fire  = r_s_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_s_valid || (s_fire && !s_two_wr);

    assign fl_wr1    = r_move_pend && (r_count != FULL);
    assign fl_count1 = r_count + CW'(fl_wr1);
    assign fl_wr2    = r_scroll_pend && (fl_count1 != FULL);

    always_comb begin
        n_rp          = r_rp;
        n_wp          = r_wp;
        n_count       = r_count;
        n_move_pend   = r_move_pend;
        n_scroll_pend = r_scroll_pend;
        n_move_slot   = r_move_slot;
        n_scroll_slot = r_scroll_slot;
        s_two_wr      = 1'b0;
        s_pop_hit     = 1'b0;
        s_dropped     = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = r_wp;
        wr_data       = r_s_entry;
        case (r_s_op)
            cerq_pkg::OP_PUSH: begin
                if (r_s_entry.ev_type == r_cfg_move) begin
                    n_move_slot = r_s_entry;
                    n_move_pend = 1'b1;
                end else if (r_s_entry.ev_type == r_cfg_scroll) begin
                    if (r_scroll_pend) begin
                        n_scroll_slot.dx = sum_x;
                        n_scroll_slot.dy = sum_y;
                    end else begin
                        n_scroll_slot = r_s_entry;
                        n_scroll_pend = 1'b1;
                    end
                end else begin
                    wr_en = 1'b1;
                    n_wp  = next_ptr(r_wp);
                    if (r_count == FULL) begin
                        n_rp      = next_ptr(r_rp);
                        s_dropped = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            cerq_pkg::OP_FLUSH: begin
                n_move_pend   = 1'b0;
                n_scroll_pend = 1'b0;
                wr_en         = fl_wr1 || fl_wr2;
                wr_data       = fl_wr1 ? r_move_slot : r_scroll_slot;
                s_two_wr      = fl_wr1 && fl_wr2;
                n_count       = fl_count1 + CW'(fl_wr2);
                if (fl_wr1 && fl_wr2) begin
                    n_wp = next_ptr(next_ptr(r_wp));
                end else if (fl_wr1 || fl_wr2) begin
                    n_wp = next_ptr(r_wp);
                end
            end
            cerq_pkg::OP_POP: begin
                if (r_count != '0) begin
                    s_pop_hit = 1'b1;
                    n_rp      = next_ptr(r_rp);
                    n_count   = r_count - 1'b1;
                end
            end
            cerq_pkg::OP_CLEAR: begin
                n_rp          = '0;
                n_wp          = '0;
                n_count       = '0;
                n_move_pend   = 1'b0;
                n_scroll_pend = 1'b0;
            end
            default: begin
                n_rp = r_rp;
            end
        endcase
    end

    assign s_size = SW'(n_count) + SW'(n_move_pend) + SW'(n_scroll_pend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_move   <= cerq_pkg::MOVE_CODE_RESET;
            r_cfg_scroll <= cerq_pkg::SCROLL_CODE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cerq_pkg::CFG_MOVE_CODE:   r_cfg_move   <= i_cfg_data;
                cerq_pkg::CFG_SCROLL_CODE: r_cfg_scroll <= i_cfg_data;
                default: r_cfg_move <= r_cfg_move;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (s_fire || o_ready) begin
            r_s_valid <= i_valid && o_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s_op            <= cerq_pkg::t_op'(i_op);
            r_s_entry.ev_type <= i_event_type;
            r_s_entry.dx      <= i_delta_x;
            r_s_entry.dy      <= i_delta_y;
            r_s_entry.data    <= i_event_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp          <= '0;
            r_wp          <= '0;
            r_count       <= '0;
            r_move_pend   <= 1'b0;
            r_scroll_pend <= 1'b0;
            r_defer       <= 1'b0;
        end else begin
            r_defer <= s_fire && s_two_wr;
            if (s_fire) begin
                r_rp          <= n_rp;
                r_wp          <= n_wp;
                r_count       <= n_count;
                r_move_pend   <= n_move_pend;
                r_scroll_pend <= n_scroll_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_move_slot   <= n_move_slot;
            r_scroll_slot <= n_scroll_slot;
            r_defer_addr  <= next_ptr(r_wp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_defer) begin
            r_mem[r_defer_addr] <= r_scroll_slot;
        end else if (s_fire && wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            if (s_pop_hit) begin
                r_o_entry <= r_mem[r_rp];
            end else begin
                r_o_entry <= '0;
            end
            r_o_pop_valid <= s_pop_hit;
            r_o_dropped   <= s_dropped;
            r_o_size      <= 7'(s_size);
            r_o_empty     <= (s_size == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s_fire) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_pop_valid      = r_o_pop_valid;
    assign o_out_type       = r_o_entry.ev_type;
    assign o_out_delta_x    = r_o_entry.dx;
    assign o_out_delta_y    = r_o_entry.dy;
    assign o_out_data       = r_o_entry.data;
    assign o_dropped_oldest = r_o_dropped;
    assign o_pending_size   = r_o_size;
    assign o_all_empty      = r_o_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("Ring count exceeds the ring depth.");

    a_defer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_defer |-> !r_s_valid)
        else $error("An item is in the input register during the second flush write.");

    a_defer_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_defer |-> (r_count >= CW'(2)))
        else $error("Second flush write without two new ring entries.");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && s_dropped) |=> (r_count == FULL))
        else $error("Oldest entry dropped but the ring is not full afterward.");

endmodule
